>>> hdl/mws_pkg.sv
`timescale 1ns / 1ps
package mws_pkg;

  // Fixed field widths
  localparam int unsigned DATA_W = 32;
  localparam int unsigned SUM_W  = 44;

  // Percentile ranks are rounded after a division by ten
  localparam int unsigned DEC_BASE = 10;
  localparam int unsigned DEC_HALF = 5;

  // Division by ten as a multiplication by ceil(2^23 / 10) and a shift; exact below 2^22
  localparam int unsigned DEC_RECIP   = 838861;
  localparam int unsigned DEC_RECIP_W = 20;
  localparam int unsigned DEC_SHIFT   = 23;

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_MISSING = 2'd0,
    REG_INVALID = 2'd1,
    REG_FILL    = 2'd2
  } reg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_INS_RD,
    ST_INS_CMP,
    ST_END,
    ST_W_MEAN,
    ST_RD_LO,
    ST_RD_HI,
    ST_OUT
  } state_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic     take;
    logic     rd_prev;
    logic     shift;
    logic     place;
    logic     div_start;
    logic     save_mean;
    logic     save_lo_idx;
    logic     save_hi_idx;
    logic     rd_lo;
    logic     rd_hi;
    logic     load_out;
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic ins_go;
    logic last;
    logic pos_zero;
    logic shift_more;
    logic cnt_zero;
    logic div_done;
    logic out_free;
  } status_t;

endpackage

>>> hdl/masked_window_statistics.sv
`timescale 1ns / 1ps
// Masked window statistics: takes one frame of signed 32-bit samples, one word per accepted
// input, skipping samples flagged outside the grid or equal to the missing or invalid code,
// and emits one result word at the sample marked last: count, sum, minimum, maximum, mean
// (truncated toward zero) and the 10th and 90th percentile samples at rounded ranks, or the
// fill value for an empty frame. Samples are kept sorted in a single-port-write store by
// insertion: an accepted sample walks down from the end of the store, moving each stored
// sample larger than it up by one place, while a skipped sample is not stored. At the end
// of a frame one iterative divider (one quotient bit per cycle, 44 steps) computes the mean
// while both percentile ranks come from a reciprocal multiplication, and the result word is
// loaded once both percentile samples are read, or at once for an empty frame, as soon as
// the output register is free. The result waits in an output register, so it can be held
// by out_stall while the next frame loads. Samples beyond MAX_SAMPLES in a frame are dropped
// and flagged.
module masked_window_statistics #(
  parameter int unsigned MAX_SAMPLES = 4096
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [3:0]                            paddr,
  input  logic [31:0]                           pwdata,
  output logic [31:0]                           prdata,
  output logic                                  pready,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic [31:0]                           in_sample_value,
  input  logic                                  in_in_grid,
  input  logic                                  in_last_sample,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic [$clog2(MAX_SAMPLES + 1)-1:0]    out_valid_count,
  output logic [43:0]                           out_sum_total,
  output logic [31:0]                           out_min_value,
  output logic [31:0]                           out_max_value,
  output logic [31:0]                           out_mean_value,
  output logic [31:0]                           out_low_decile,
  output logic [31:0]                           out_high_decile,
  output logic                                  out_outside_seen,
  output logic                                  out_store_overflow
);

  localparam int unsigned CW = $clog2(MAX_SAMPLES + 1);

  logic [31:0]      missing_r;
  logic [31:0]      invalid_r;
  logic [31:0]      fill_r;
  logic             cfg_wr;
  mws_pkg::cmd_t    cmd;
  mws_pkg::status_t status;

  // Configuration registers
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      missing_r <= 32'h8000_0000;
      invalid_r <= 32'h8000_0001;
      fill_r    <= '0;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        mws_pkg::REG_MISSING: missing_r <= pwdata;
        mws_pkg::REG_INVALID: invalid_r <= pwdata;
        mws_pkg::REG_FILL:    fill_r    <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      mws_pkg::REG_MISSING: prdata = missing_r;
      mws_pkg::REG_INVALID: prdata = invalid_r;
      mws_pkg::REG_FILL:    prdata = fill_r;
      default:              prdata = '0;
    endcase
  end

  mws_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .status  (status),
    .cmd     (cmd)
  );

  mws_datapath #(
    .MAX_SAMPLES(MAX_SAMPLES),
    .CW         (CW)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .status            (status),
    .missing_code      (missing_r),
    .invalid_code      (invalid_r),
    .empty_fill        (fill_r),
    .in_sample_value   (in_sample_value),
    .in_in_grid        (in_in_grid),
    .in_last_sample    (in_last_sample),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_valid_count   (out_valid_count),
    .out_sum_total     (out_sum_total),
    .out_min_value     (out_min_value),
    .out_max_value     (out_max_value),
    .out_mean_value    (out_mean_value),
    .out_low_decile    (out_low_decile),
    .out_high_decile   (out_high_decile),
    .out_outside_seen  (out_outside_seen),
    .out_store_overflow(out_store_overflow)
  );

endmodule

>>> hdl/mws_div.sv
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle.
module mws_div #(
  parameter int unsigned DVW = 44,
  parameter int unsigned DSW = 17
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  logic [DVW-1:0] dividend,
  input  logic [DSW-1:0] divisor,
  output logic [DVW-1:0] quotient,
  output logic           done
);

  localparam int unsigned SCW = $clog2(DVW + 1);

  logic [DSW-1:0] rem_r;
  logic [DVW-1:0] quo_r;
  logic [DSW-1:0] dvs_r;
  logic [SCW-1:0] steps_r;
  logic           busy_r;
  logic           done_r;
  logic [DSW:0]   trial;
  logic           fits;
  logic [DSW:0]   diff;

  // One trial subtraction of the shifted partial remainder
  always_comb begin
    trial = {rem_r, quo_r[DVW-1]};
    fits  = trial >= {1'b0, dvs_r};
    diff  = trial - {1'b0, dvs_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      done_r  <= 1'b0;
      steps_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r  <= 1'b1;
        steps_r <= '0;
      end else if (busy_r) begin
        steps_r <= steps_r + 1'b1;
        if (steps_r == SCW'(DVW - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
      dvs_r <= divisor;
    end else if (busy_r) begin
      rem_r <= fits ? diff[DSW-1:0] : trial[DSW-1:0];
      quo_r <= {quo_r[DVW-2:0], fits};
    end
  end

  assign quotient = quo_r;
  assign done     = done_r;

endmodule

>>> hdl/mws_datapath.sv
`timescale 1ns / 1ps
module mws_datapath #(
  parameter int unsigned MAX_SAMPLES = 4096,
  parameter int unsigned CW          = 13
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  mws_pkg::cmd_t         cmd,
  output mws_pkg::status_t      status,
  input  logic [31:0]           missing_code,
  input  logic [31:0]           invalid_code,
  input  logic [31:0]           empty_fill,
  input  logic [31:0]           in_sample_value,
  input  logic                  in_in_grid,
  input  logic                  in_last_sample,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [CW-1:0]         out_valid_count,
  output logic [43:0]           out_sum_total,
  output logic [31:0]           out_min_value,
  output logic [31:0]           out_max_value,
  output logic [31:0]           out_mean_value,
  output logic [31:0]           out_low_decile,
  output logic [31:0]           out_high_decile,
  output logic                  out_outside_seen,
  output logic                  out_store_overflow
);

  localparam int unsigned AW  = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
  localparam int unsigned DSW = (CW > 4) ? CW : 4;
  localparam int unsigned SW  = mws_pkg::SUM_W;
  localparam int unsigned DW  = mws_pkg::DATA_W;
  localparam int unsigned XW  = CW + 4;
  localparam int unsigned PW  = XW + mws_pkg::DEC_RECIP_W;

  logic [DW-1:0]  store_r [MAX_SAMPLES];
  logic [DW-1:0]  rd_r;
  logic [DW-1:0]  v_r;
  logic           last_r;
  logic           ins_r;
  logic [CW-1:0]  cnt_r;
  logic [CW-1:0]  pos_r;
  logic [SW-1:0]  sum_r;
  logic [DW-1:0]  min_r;
  logic [DW-1:0]  max_r;
  logic           outside_r;
  logic           ovf_r;
  logic [DW-1:0]  mean_r;
  logic [DW-1:0]  lo_r;
  logic [AW-1:0]  idx_lo_r;
  logic [AW-1:0]  idx_hi_r;
  logic [XW-1:0]  tenth_lo_r;
  logic [XW-1:0]  tenth_hi_r;
  logic           out_valid_r;

  logic           keep;
  logic           full;
  logic [CW-1:0]  cnt_m1;
  logic [XW-1:0]  rank_lo_num;
  logic [XW-1:0]  rank_hi_num;
  logic [PW-1:0]  prod_lo;
  logic [PW-1:0]  prod_hi;
  logic [SW-1:0]  sum_abs;
  logic [SW-1:0]  div_a;
  logic [DSW-1:0] div_b;
  logic [SW-1:0]  quo;
  logic           div_done;
  logic [DW-1:0]  mean_nxt;
  logic           we;
  logic [AW-1:0]  wa;
  logic [DW-1:0]  wd;
  logic [AW-1:0]  ra;
  logic           re;

  // Rank from num / 10 rounded to nearest, ties to even, given the truncated quotient.
  function automatic logic [AW-1:0] round_rank(input logic [XW-1:0] num,
                                               input logic [XW-1:0] quot);
    logic [XW-1:0] rmd;
    logic          up;
    rmd = num - ((quot << 3) + (quot << 1));
    up  = (rmd > XW'(mws_pkg::DEC_HALF))
          || ((rmd == XW'(mws_pkg::DEC_HALF)) && quot[0]);
    return AW'(quot + XW'(up));
  endfunction

  // Sample qualification at the accepting edge
  always_comb begin
    keep = in_in_grid && (in_sample_value != missing_code)
           && (in_sample_value != invalid_code);
    full = (cnt_r == CW'(MAX_SAMPLES));
  end

  // Frame accumulators
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r     <= '0;
      sum_r     <= '0;
      min_r     <= '0;
      max_r     <= '0;
      outside_r <= 1'b0;
      ovf_r     <= 1'b0;
      ins_r     <= 1'b0;
      last_r    <= 1'b0;
    end else if (cmd.load_out) begin
      cnt_r     <= '0;
      sum_r     <= '0;
      min_r     <= '0;
      max_r     <= '0;
      outside_r <= 1'b0;
      ovf_r     <= 1'b0;
    end else if (cmd.take) begin
      last_r <= in_last_sample;
      ins_r  <= keep && !full;
      if (!in_in_grid) begin
        outside_r <= 1'b1;
      end
      if (keep && full) begin
        ovf_r <= 1'b1;
      end
      if (keep && !full) begin
        sum_r <= sum_r + {{(SW-DW){in_sample_value[DW-1]}}, in_sample_value};
        if (cnt_r == '0 || $signed(in_sample_value) < $signed(min_r)) begin
          min_r <= in_sample_value;
        end
        if (cnt_r == '0 || $signed(in_sample_value) > $signed(max_r)) begin
          max_r <= in_sample_value;
        end
      end
    end else if (cmd.place) begin
      cnt_r <= cnt_r + 1'b1;
    end
  end

  // Insertion position walks down from the end of the sorted store
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      v_r   <= in_sample_value;
      pos_r <= cnt_r;
    end else if (cmd.shift) begin
      pos_r <= pos_r - 1'b1;
    end
  end

  // Store port selection
  always_comb begin
    we = cmd.shift || cmd.place;
    wa = pos_r[AW-1:0];
    wd = cmd.shift ? rd_r : v_r;
    re = cmd.rd_prev || cmd.rd_lo || cmd.rd_hi;
    priority if (cmd.rd_lo) begin
      ra = idx_lo_r;
    end else if (cmd.rd_hi) begin
      ra = idx_hi_r;
    end else begin
      ra = AW'(pos_r - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      store_r[wa] <= wd;
    end
    if (re) begin
      rd_r <= store_r[ra];
    end
  end

  // Percentile rank numerators and their reciprocal products
  always_comb begin
    cnt_m1      = cnt_r - 1'b1;
    rank_lo_num = XW'(cnt_m1);
    rank_hi_num = (rank_lo_num << 3) + rank_lo_num;
    prod_lo     = PW'(rank_lo_num) * PW'(mws_pkg::DEC_RECIP);
    prod_hi     = PW'(rank_hi_num) * PW'(mws_pkg::DEC_RECIP);
  end

  // The count holds still at the end of a frame, so the quotients settle while the mean runs.
  always_ff @(posedge clk) begin
    tenth_lo_r <= XW'(prod_lo[PW-1:mws_pkg::DEC_SHIFT]);
    tenth_hi_r <= XW'(prod_hi[PW-1:mws_pkg::DEC_SHIFT]);
  end

  // Divider operands for the mean
  always_comb begin
    sum_abs = sum_r[SW-1] ? (~sum_r + 1'b1) : sum_r;
    div_a   = sum_abs;
    div_b   = DSW'(cnt_r);
  end

  mws_div #(
    .DVW(SW),
    .DSW(DSW)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (div_a),
    .divisor  (div_b),
    .quotient (quo),
    .done     (div_done)
  );

  // Sign of the mean
  always_comb begin
    mean_nxt = sum_r[SW-1] ? (~quo[DW-1:0] + 1'b1) : quo[DW-1:0];
  end

  always_ff @(posedge clk) begin
    if (cmd.save_mean) begin
      mean_r <= mean_nxt;
    end
    if (cmd.save_lo_idx) begin
      idx_lo_r <= round_rank(rank_lo_num, tenth_lo_r);
    end
    if (cmd.save_hi_idx) begin
      idx_hi_r <= round_rank(rank_hi_num, tenth_hi_r);
    end
    if (cmd.rd_hi) begin
      lo_r <= rd_r;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_valid_count    <= cnt_r;
      out_sum_total      <= sum_r;
      out_outside_seen   <= outside_r;
      out_store_overflow <= ovf_r;
      if (cnt_r == '0) begin
        out_min_value   <= empty_fill;
        out_max_value   <= empty_fill;
        out_mean_value  <= empty_fill;
        out_low_decile  <= empty_fill;
        out_high_decile <= empty_fill;
      end else begin
        out_min_value   <= min_r;
        out_max_value   <= max_r;
        out_mean_value  <= mean_r;
        out_low_decile  <= lo_r;
        out_high_decile <= rd_r;
      end
    end
  end

  assign out_valid = out_valid_r;

  always_comb begin
    status.ins_go     = ins_r;
    status.last       = last_r;
    status.pos_zero   = (pos_r == '0);
    status.shift_more = $signed(rd_r) > $signed(v_r);
    status.cnt_zero   = (cnt_r == '0);
    status.div_done   = div_done;
    status.out_free   = !out_valid_r || !out_stall;
  end

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(MAX_SAMPLES))
    else $error("sample count beyond store depth");

  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |=> (cnt_r == '0) && !ovf_r && !outside_r)
    else $error("frame state not cleared after result");

  a_minmax: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r != '0) |-> ($signed(min_r) <= $signed(max_r)))
    else $error("running minimum above running maximum");

  a_no_lost_word: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> (!out_valid_r || !out_stall))
    else $error("result word overwritten while stalled");
`endif

endmodule

>>> hdl/mws_ctrl.sv
`timescale 1ns / 1ps
module mws_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  mws_pkg::status_t status,
  output mws_pkg::cmd_t    cmd
);

  mws_pkg::state_t state_r;
  mws_pkg::state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mws_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and command decode
  always_comb begin
    state_nxt   = state_r;
    cmd         = '0;
    in_stall    = 1'b1;
    unique case (state_r)
      mws_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.take  = 1'b1;
          state_nxt = mws_pkg::ST_DECIDE;
        end
      end
      mws_pkg::ST_DECIDE: begin
        if (status.ins_go) begin
          state_nxt = mws_pkg::ST_INS_RD;
        end else if (status.last) begin
          state_nxt = mws_pkg::ST_END;
        end else begin
          state_nxt = mws_pkg::ST_IDLE;
        end
      end
      mws_pkg::ST_INS_RD: begin
        if (status.pos_zero) begin
          cmd.place = 1'b1;
          state_nxt = status.last ? mws_pkg::ST_END : mws_pkg::ST_IDLE;
        end else begin
          cmd.rd_prev = 1'b1;
          state_nxt   = mws_pkg::ST_INS_CMP;
        end
      end
      mws_pkg::ST_INS_CMP: begin
        if (status.shift_more) begin
          cmd.shift = 1'b1;
          state_nxt = mws_pkg::ST_INS_RD;
        end else begin
          cmd.place = 1'b1;
          state_nxt = status.last ? mws_pkg::ST_END : mws_pkg::ST_IDLE;
        end
      end
      mws_pkg::ST_END: begin
        if (status.cnt_zero) begin
          state_nxt = mws_pkg::ST_OUT;
        end else begin
          cmd.div_start = 1'b1;
          state_nxt     = mws_pkg::ST_W_MEAN;
        end
      end
      mws_pkg::ST_W_MEAN: begin
        if (status.div_done) begin
          cmd.save_mean   = 1'b1;
          cmd.save_lo_idx = 1'b1;
          cmd.save_hi_idx = 1'b1;
          state_nxt       = mws_pkg::ST_RD_LO;
        end
      end
      mws_pkg::ST_RD_LO: begin
        cmd.rd_lo = 1'b1;
        state_nxt = mws_pkg::ST_RD_HI;
      end
      mws_pkg::ST_RD_HI: begin
        cmd.rd_hi = 1'b1;
        state_nxt = mws_pkg::ST_OUT;
      end
      mws_pkg::ST_OUT: begin
        if (status.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = mws_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = mws_pkg::ST_IDLE;
      end
    endcase
  end

`ifndef SYNTHESIS
  a_take_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.take |=> (state_r == mws_pkg::ST_DECIDE))
    else $error("accepted word not followed by decision");

  a_div_chain: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_start |=> (state_r == mws_pkg::ST_W_MEAN))
    else $error("divider sequence out of order");

  a_place_once: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.place |=> !cmd.place)
    else $error("sample placed twice");
`endif

endmodule

>>> bench/tb_masked_window_statistics.sv
`timescale 1ns / 1ps
module tb_masked_window_statistics;

  localparam int unsigned STORE_DEPTH = 4096;
  localparam int unsigned DRAIN_CYCLES = 300;

  // Statistics of one frame as the block reports them.
  typedef struct {
    logic [12:0] count;
    logic [43:0] sum;
    logic [31:0] mn;
    logic [31:0] mx;
    logic [31:0] mean;
    logic [31:0] lo;
    logic [31:0] hi;
    logic        outside;
    logic        ovf;
  } frame_stats_t;

  // Keeps a sorted copy of the frame and the queue of frame statistics still owed.
  class frame_stats_board;
    logic signed [31:0] missing_code = 32'sh8000_0000;
    logic signed [31:0] invalid_code = 32'sh8000_0001;
    logic signed [31:0] empty_fill   = 32'sh0;
    int                 sorted_samples[$];
    logic signed [43:0] running_sum;
    logic signed [31:0] running_min, running_max;
    bit                 outside_flag, overflow_flag;
    frame_stats_t       pending_stats[$];
    int                 errors;

    function void clear_frame();
      sorted_samples.delete();
      running_sum = '0;
      running_min = '0;
      running_max = '0;
      outside_flag = 0;
      overflow_flag = 0;
    endfunction

    // Rounds num/10 to the nearest integer, ties to even.
    function int round_tenth(int num);
      int q;
      int r;
      q = num / mws_pkg::DEC_BASE;
      r = num % mws_pkg::DEC_BASE;
      if (r > mws_pkg::DEC_HALF || (r == mws_pkg::DEC_HALF && q[0])) q++;
      return q;
    endfunction

    function void note_sample(logic signed [31:0] v, bit grid, bit last);
      int           pos;
      int           n;
      longint       wide_sum;
      frame_stats_t st;
      if (!grid) begin
        outside_flag = 1;
      end else if (v != missing_code && v != invalid_code) begin
        if (sorted_samples.size() >= STORE_DEPTH) begin
          overflow_flag = 1;
        end else begin
          pos = sorted_samples.size();
          while (pos > 0 && sorted_samples[pos-1] > v) pos--;
          if (sorted_samples.size() == 0 || v < running_min) running_min = v;
          if (sorted_samples.size() == 0 || v > running_max) running_max = v;
          sorted_samples.insert(pos, v);
          running_sum = running_sum + {{12{v[31]}}, v};
        end
      end
      if (!last) return;
      n = sorted_samples.size();
      st.count = 13'(n);
      st.sum = running_sum;
      st.outside = outside_flag;
      st.ovf = overflow_flag;
      if (n > 0) begin
        wide_sum = longint'(running_sum);
        st.mn = running_min;
        st.mx = running_max;
        st.mean = 32'(wide_sum / longint'(n));
        st.lo = sorted_samples[round_tenth(n - 1)];
        st.hi = sorted_samples[round_tenth((n - 1) * 9)];
      end else begin
        st.mn = empty_fill;
        st.mx = empty_fill;
        st.mean = empty_fill;
        st.lo = empty_fill;
        st.hi = empty_fill;
      end
      pending_stats.push_back(st);
      clear_frame();
    endfunction

    function void compare_field(string name, logic [63:0] exp, logic [63:0] act);
      if (exp !== act) begin
        errors++;
        $display("%0t: %s mismatch, expected %h, got %h", $realtime, name, exp, act);
      end
    endfunction

    function void check_stats(frame_stats_t got);
      frame_stats_t exp;
      if (pending_stats.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, got count %0d", $realtime,
                 got.count);
        return;
      end
      exp = pending_stats.pop_front();
      compare_field("valid_count", 64'(exp.count), 64'(got.count));
      compare_field("sum_total", 64'(exp.sum), 64'(got.sum));
      compare_field("min_value", 64'(exp.mn), 64'(got.mn));
      compare_field("max_value", 64'(exp.mx), 64'(got.mx));
      compare_field("mean_value", 64'(exp.mean), 64'(got.mean));
      compare_field("low_decile", 64'(exp.lo), 64'(got.lo));
      compare_field("high_decile", 64'(exp.hi), 64'(got.hi));
      compare_field("outside_seen", 64'(exp.outside), 64'(got.outside));
      compare_field("store_overflow", 64'(exp.ovf), 64'(got.ovf));
    endfunction
  endclass

  logic        clk = 0;
  logic        rst_n = 0;
  logic        psel = 0, penable = 0, pwrite = 0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid = 0;
  logic        in_stall;
  logic [31:0] in_sample_value = '0;
  logic        in_in_grid = 0, in_last_sample = 0;
  logic        out_valid;
  logic        out_stall = 0;
  logic [12:0] out_valid_count;
  logic [43:0] out_sum_total;
  logic [31:0] out_min_value, out_max_value, out_mean_value, out_low_decile, out_high_decile;
  logic        out_outside_seen, out_store_overflow;

  frame_stats_board board = new();
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;

  always #4 clk = ~clk;

  masked_window_statistics #(.MAX_SAMPLES(STORE_DEPTH)) u_dut (.*);

  // The receiver stalls at random with the current phase's weight.
  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // Every accepted result word is checked against the oldest prediction.
  always @(posedge clk) begin
    frame_stats_t got;
    if (rst_n && out_valid && !out_stall) begin
      got.count = out_valid_count;
      got.sum = out_sum_total;
      got.mn = out_min_value;
      got.mx = out_max_value;
      got.mean = out_mean_value;
      got.lo = out_low_decile;
      got.hi = out_high_decile;
      got.outside = out_outside_seen;
      got.ovf = out_store_overflow;
      board.check_stats(got);
    end
  end

  task automatic write_reg(mws_pkg::reg_idx_t idx, logic [31:0] value);
    @(negedge clk);
    psel = 1;
    pwrite = 1;
    penable = 0;
    paddr = {idx, 2'b00};
    pwdata = value;
    @(negedge clk);
    penable = 1;
    do @(posedge clk); while (!pready);
    case (idx)
      mws_pkg::REG_MISSING: board.missing_code = value;
      mws_pkg::REG_INVALID: board.invalid_code = value;
      mws_pkg::REG_FILL:    board.empty_fill = value;
      default: ;
    endcase
    @(negedge clk);
    psel = 0;
    penable = 0;
    pwrite = 0;
  endtask

  task automatic send_sample(logic [31:0] v, bit grid, bit last);
    @(negedge clk);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid = 0;
      repeat ($urandom_range(4, 1)) @(negedge clk);
    end
    in_valid = 1;
    in_sample_value = v;
    in_in_grid = grid;
    in_last_sample = last;
    do @(posedge clk); while (in_stall);
    board.note_sample(v, grid, last);
  endtask

  task automatic release_input();
    @(negedge clk);
    in_valid = 0;
  endtask

  // Waits until every predicted result has been seen, then lets the block settle.
  task automatic drain();
    release_input();
    while (board.pending_stats.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic [31:0] pick_sample();
    int sel;
    sel = $urandom_range(99);
    if (sel < 8) return board.missing_code;
    if (sel < 16) return board.invalid_code;
    if (sel < 22) return ($urandom_range(1)) ? 32'h7fff_ffff : 32'h8000_0000;
    if (sel < 50) return $urandom_range(8) - 4;
    return $urandom();
  endfunction

  task automatic random_frames(int n_items);
    int sent;
    int len;
    sent = 0;
    while (sent < n_items) begin
      len = ($urandom_range(9) == 0) ? $urandom_range(40, 1) : $urandom_range(14, 1);
      for (int i = 0; i < len; i++)
        send_sample(pick_sample(), $urandom_range(15) != 0, i == len - 1);
      // The last sample of each frame ends it, skipped or not.
      sent += len;
    end
  endtask

  initial begin
    #20ms;
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    board.clear_frame();
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    // Directed frames under the reset codes: extremes, skipped samples, outside samples,
    // a last marker on a skipped sample, an empty frame, an outside-only frame, a ramp and a repeated maximum.
    send_sample(32'h7fff_ffff, 1, 0);
    send_sample(32'h8000_0000, 1, 0);
    send_sample(32'h8000_0001, 1, 0);
    send_sample(32'h8000_0002, 1, 0);
    send_sample(32'h0000_0000, 0, 0);
    send_sample(32'hffff_ffff, 1, 0);
    send_sample(32'h8000_0000, 1, 1);
    send_sample(32'h8000_0001, 1, 1);
    send_sample(32'h1234_5678, 0, 1);
    for (int i = 0; i < 11; i++) send_sample(32'(i * 3 - 7), 1, i == 10);
    send_sample(32'h7fff_ffff, 1, 0);
    send_sample(32'h7fff_ffff, 1, 1);
    drain();

    // Phases of pressure, each under its own set of codes.
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          send_idle_pct = 0;  recv_stall_pct = 0;
          write_reg(mws_pkg::REG_MISSING, 32'h0);
          write_reg(mws_pkg::REG_INVALID, 32'h7fff_ffff);
          write_reg(mws_pkg::REG_FILL, 32'h8000_0000);
        end
        1: begin
          send_idle_pct = 75; recv_stall_pct = 0;
          write_reg(mws_pkg::REG_MISSING, 32'h7fff_ffff);
          write_reg(mws_pkg::REG_INVALID, 32'h8000_0000);
          write_reg(mws_pkg::REG_FILL, 32'h7fff_ffff);
        end
        2: begin
          send_idle_pct = 0;  recv_stall_pct = 75;
          write_reg(mws_pkg::REG_MISSING, $urandom_range(8) - 4);
          write_reg(mws_pkg::REG_INVALID, $urandom());
          write_reg(mws_pkg::REG_FILL, $urandom());
        end
        default: begin
          send_idle_pct = 33; recv_stall_pct = 33;
          write_reg(mws_pkg::REG_MISSING, 32'hffff_ffff);
          write_reg(mws_pkg::REG_INVALID, 32'h1);
          write_reg(mws_pkg::REG_FILL, 32'hffff_ffff);
        end
      endcase
      random_frames(200);
      drain();
    end

    if (board.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
